>>> rtl/matrix_duplicate_row_col_removal_top_assert.svh
// assertion macros for the duplicate row/column removal block
// used by the port checker; no other dependencies
`ifndef MATRIX_DUPLICATE_ROW_COL_REMOVAL_TOP_ASSERT_SVH
`define MATRIX_DUPLICATE_ROW_COL_REMOVAL_TOP_ASSERT_SVH

// same-cycle implication
`define MDRC_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define MDRC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/mdrc_pkg.sv
// shared types and constants of the duplicate row/column removal block
// no dependencies
`default_nettype none

package mdrc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIM_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] element_value;
  } mdrc_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     end_of_row;
    logic                     last_element;
    logic [DIM_W-1:0]         kept_rows;
    logic [DIM_W-1:0]         kept_cols;
    logic                     no_data;
  } mdrc_rsp_t;

  typedef struct packed {
    logic restart;
    logic load;
    logic rd_nodata;
    logic rd_issue;
    logic rd_capture;
    logic pass_init_row;
    logic pass_init_col;
    logic a_inc;
    logic b_inc;
    logic scan_start;
    logic scan_issue;
    logic decide;
    logic read_init;
  } mdrc_cmd_t;

  typedef struct packed {
    logic ld_last;
    logic unit_dims;
    logic rd_done;
    logic out_busy;
    logic pass_done;
    logic a_ge_b;
    logic keep_a;
    logic keep_b;
    logic scan_last;
    logic col_mode;
  } mdrc_sts_t;

endpackage

`default_nettype wire

>>> rtl/mdrc_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
`default_nettype none

module mdrc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> rtl/mdrc_ctrl.sv
// controller state machine: request handling and duplicate-removal walk sequencing
// depends on mdrc_pkg
`default_nettype none

module mdrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_req_type_i,
  input  logic                cfg_we_i,
  input  mdrc_pkg::mdrc_sts_t sts_i,
  output logic                in_stall_o,
  output mdrc_pkg::mdrc_cmd_t cmd_o
);
  import mdrc_pkg::*;

  typedef enum logic [6:0] {
    S_LOADING = 7'b0000001,
    S_READING = 7'b0000010,
    S_RDWAIT  = 7'b0000100,
    S_PAIR    = 7'b0001000,
    S_SCAN    = 7'b0010000,
    S_DRAIN   = 7'b0100000,
    S_DECIDE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   idle, is_read, accept;

  always_comb begin
    is_read    = (in_req_type_i == REQ_READ);
    idle       = (state_q == S_LOADING) || (state_q == S_READING);
    in_stall_o = !idle || cfg_we_i || (is_read && sts_i.out_busy);
    accept     = in_valid_i && !in_stall_o;
    cmd_o      = '0;
    state_d    = state_q;
    case (state_q)
      S_LOADING: begin
        if (accept) begin
          if (is_read) begin
            cmd_o.rd_nodata = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            if (sts_i.ld_last) begin
              cmd_o.pass_init_row = 1'b1;
              state_d             = S_PAIR;
            end
          end
        end
      end
      S_READING: begin
        if (accept) begin
          if (is_read) begin
            if (sts_i.rd_done) begin
              cmd_o.rd_nodata = 1'b1;
            end else begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_RDWAIT;
            end
          end else begin
            cmd_o.restart = 1'b1;
            cmd_o.load    = 1'b1;
            if (sts_i.unit_dims) begin
              cmd_o.pass_init_row = 1'b1;
              state_d             = S_PAIR;
            end else begin
              state_d = S_LOADING;
            end
          end
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_READING;
      end
      S_PAIR: begin
        if (sts_i.pass_done) begin
          if (sts_i.col_mode) begin
            cmd_o.read_init = 1'b1;
            state_d         = S_READING;
          end else begin
            cmd_o.pass_init_col = 1'b1;
          end
        end else if (sts_i.a_ge_b || !sts_i.keep_b) begin
          cmd_o.b_inc = 1'b1;
        end else if (!sts_i.keep_a) begin
          cmd_o.a_inc = 1'b1;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_PAIR;
      end
      default: begin
        state_d = S_LOADING;
      end
    endcase
    if (cfg_we_i) begin
      state_d = S_LOADING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOADING;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mdrc_dp.sv
// datapath: config, matrix store, keep masks, walk counters, read pointers, output register
// depends on mdrc_pkg and mdrc_ram
`default_nettype none

module mdrc_dp #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mdrc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mdrc_pkg::DIM_W-1:0]           cfg_data_i,
  input  logic signed [mdrc_pkg::DATA_W-1:0]   element_value_i,
  input  mdrc_pkg::mdrc_cmd_t                  cmd_i,
  output mdrc_pkg::mdrc_sts_t                  sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mdrc_pkg::mdrc_rsp_t                  out_rsp_o
);
  import mdrc_pkg::*;

  localparam int unsigned MAX_D = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned CNT_W = $clog2(MAX_D + 1);
  localparam int unsigned CW    = (CNT_W > DIM_W) ? CNT_W : DIM_W;
  localparam int unsigned RIW   = $clog2(MAX_ROWS);
  localparam int unsigned CIW   = $clog2(MAX_COLS);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (32'(v) > maxv) begin
      return DIM_W'(maxv);
    end
    return v;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r[RIW-1:0]) * AW'(MAX_COLS) + AW'(c[CIW-1:0]);
  endfunction

  logic [DIM_W-1:0]    num_rows_q, num_cols_q;
  logic [MAX_ROWS-1:0] row_keep_q;
  logic [MAX_COLS-1:0] col_keep_q;
  logic [CW-1:0]       ld_row_q, ld_col_q;
  logic [CW-1:0]       a_q, b_q, k_q, cmp_k_q;
  logic [CW-1:0]       rd_row_q, rd_col_q;
  logic                col_mode_q, rd_done_q, cmp_vld_q, mism_q;
  logic [DIM_W-1:0]    krows_q, kcols_q;
  logic                eor_q, last_q;
  logic                out_vld_q;
  mdrc_rsp_t           out_q;

  logic [DIM_W-1:0]    eff_rows, eff_cols;
  logic [CW-1:0]       rows_w, cols_w, lim_outer, lim_inner;
  logic [CW-1:0]       pos_row, pos_col;
  logic                restart, take, diff, drop;
  logic                c_found, r_found, eor, last;
  logic [CW-1:0]       c_next, r_next;
  logic [AW-1:0]       waddr, raddr_a, raddr_b, pair_a, pair_b;
  logic [DATA_W-1:0]   rdata_a, rdata_b;
  mdrc_rsp_t           rsp_d;

  always_comb begin
    eff_rows  = clamp_dim(num_rows_q, MAX_ROWS);
    eff_cols  = clamp_dim(num_cols_q, MAX_COLS);
    rows_w    = CW'(eff_rows);
    cols_w    = CW'(eff_cols);
    lim_outer = col_mode_q ? cols_w : rows_w;
    lim_inner = col_mode_q ? rows_w : cols_w;
    restart   = cfg_we_i || cmd_i.restart;
    take      = out_vld_q && !out_stall_i;
    pos_row   = cmd_i.restart ? '0 : ld_row_q;
    pos_col   = cmd_i.restart ? '0 : ld_col_q;
    drop      = cmd_i.decide && !mism_q;
  end

  always_comb begin
    sts_o.ld_last   = (ld_row_q == rows_w - CW'(1)) && (ld_col_q == cols_w - CW'(1));
    sts_o.unit_dims = (rows_w == CW'(1)) && (cols_w == CW'(1));
    sts_o.rd_done   = rd_done_q;
    sts_o.out_busy  = out_vld_q && out_stall_i;
    sts_o.pass_done = (b_q >= lim_outer);
    sts_o.a_ge_b    = (a_q >= b_q);
    sts_o.keep_a    = col_mode_q ? col_keep_q[a_q[CIW-1:0]] : row_keep_q[a_q[RIW-1:0]];
    sts_o.keep_b    = col_mode_q ? col_keep_q[b_q[CIW-1:0]] : row_keep_q[b_q[RIW-1:0]];
    sts_o.scan_last = (k_q == lim_inner - CW'(1));
    sts_o.col_mode  = col_mode_q;
  end

  // next kept column and row after the read pointer
  always_comb begin
    c_found = 1'b0;
    c_next  = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (col_keep_q[i] && (CW'(i) > rd_col_q) && (CW'(i) < cols_w)) begin
        c_found = 1'b1;
        c_next  = CW'(i);
      end
    end
    r_found = 1'b0;
    r_next  = '0;
    for (int i = MAX_ROWS - 1; i >= 0; i--) begin
      if (row_keep_q[i] && (CW'(i) > rd_row_q) && (CW'(i) < rows_w)) begin
        r_found = 1'b1;
        r_next  = CW'(i);
      end
    end
    eor  = !c_found;
    last = eor && !r_found;
  end

  always_comb begin
    pair_a  = col_mode_q ? addr_of(k_q, a_q) : addr_of(a_q, k_q);
    pair_b  = col_mode_q ? addr_of(k_q, b_q) : addr_of(b_q, k_q);
    raddr_a = cmd_i.scan_issue ? pair_a : addr_of(rd_row_q, rd_col_q);
    raddr_b = pair_b;
    waddr   = addr_of(pos_row, pos_col);
    diff    = (rdata_a != rdata_b) && (col_mode_q ? row_keep_q[cmp_k_q[RIW-1:0]] : 1'b1);
  end

  mdrc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.load),
    .waddr_i   (waddr),
    .wdata_i   (element_value_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIM_W'(1);
      num_cols_q <= DIM_W'(1);
      row_keep_q <= '1;
      col_keep_q <= '1;
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      a_q        <= '0;
      b_q        <= '0;
      k_q        <= '0;
      col_mode_q <= 1'b0;
      krows_q    <= '0;
      kcols_q    <= '0;
      rd_row_q   <= '0;
      rd_col_q   <= '0;
      rd_done_q  <= 1'b0;
      cmp_vld_q  <= 1'b0;
      mism_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
          CFG_NUM_COLS: num_cols_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (restart) begin
        row_keep_q <= '1;
        col_keep_q <= '1;
      end else if (drop) begin
        if (col_mode_q) begin
          col_keep_q[b_q[CIW-1:0]] <= 1'b0;
        end else begin
          row_keep_q[b_q[RIW-1:0]] <= 1'b0;
        end
      end

      if (cfg_we_i) begin
        ld_row_q <= '0;
        ld_col_q <= '0;
      end else if (cmd_i.load) begin
        if (pos_col == cols_w - CW'(1)) begin
          ld_col_q <= '0;
          ld_row_q <= pos_row + CW'(1);
        end else begin
          ld_col_q <= pos_col + CW'(1);
          ld_row_q <= pos_row;
        end
      end

      if (cmd_i.pass_init_row || cmd_i.pass_init_col) begin
        a_q        <= '0;
        b_q        <= CW'(1);
        col_mode_q <= cmd_i.pass_init_col;
      end else if (cmd_i.b_inc) begin
        a_q <= '0;
        b_q <= b_q + CW'(1);
      end else if (cmd_i.a_inc || cmd_i.decide) begin
        a_q <= a_q + CW'(1);
      end

      if (cmd_i.scan_start) begin
        k_q <= '0;
      end else if (cmd_i.scan_issue) begin
        k_q <= k_q + CW'(1);
      end

      cmp_vld_q <= cmd_i.scan_issue;
      if (cmd_i.scan_start) begin
        mism_q <= 1'b0;
      end else if (cmp_vld_q) begin
        mism_q <= mism_q | diff;
      end

      if (cmd_i.pass_init_row) begin
        krows_q <= eff_rows;
        kcols_q <= eff_cols;
      end else if (drop) begin
        if (col_mode_q) begin
          kcols_q <= kcols_q - DIM_W'(1);
        end else begin
          krows_q <= krows_q - DIM_W'(1);
        end
      end

      if (restart || cmd_i.read_init) begin
        rd_row_q  <= '0;
        rd_col_q  <= '0;
        rd_done_q <= 1'b0;
      end else if (cmd_i.rd_issue) begin
        if (last) begin
          rd_done_q <= 1'b1;
        end else if (eor) begin
          rd_row_q <= r_next;
          rd_col_q <= '0;
        end else begin
          rd_col_q <= c_next;
        end
      end

      if (cmd_i.rd_nodata || cmd_i.rd_capture) begin
        out_vld_q <= 1'b1;
      end else if (take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    if (cmd_i.rd_nodata) begin
      rsp_d.no_data = 1'b1;
    end else begin
      rsp_d.result_value = rdata_a;
      rsp_d.end_of_row   = eor_q;
      rsp_d.last_element = last_q;
      rsp_d.kept_rows    = krows_q;
      rsp_d.kept_cols    = kcols_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_k_q <= k_q;
    if (cmd_i.rd_issue) begin
      eor_q  <= eor;
      last_q <= last;
    end
    if (cmd_i.rd_nodata || cmd_i.rd_capture) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

>>> rtl/matrix_duplicate_row_col_removal_top.sv
// top level of the duplicate row/column removal block
// depends on mdrc_pkg, mdrc_ctrl, mdrc_dp (with mdrc_ram)
`default_nettype none

// Load requests fill a num_rows x num_cols matrix of signed 32-bit elements in
// row-major order; a load after the matrix was processed starts a new one, and a
// register write restarts loading. The last load starts a walk that drops each
// row equal to an earlier kept row, then each column equal to an earlier kept
// column over the kept rows; input stall stays high during the walk. The walk
// reads one element pair per cycle from the two read ports of the matrix store
// for each compared pair. A read request goes through the store's registered
// read port and returns the next kept element with row-end, last and kept-size
// fields; a read while the matrix is still loading, or after the last element,
// returns no_data with all other fields zero. No clearing pass is needed.
module matrix_duplicate_row_col_removal_top #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mdrc_pkg::mdrc_req_t            in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mdrc_pkg::mdrc_rsp_t            out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [mdrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdrc_pkg::DIM_W-1:0]     cfg_data_i
);
  import mdrc_pkg::*;

  mdrc_cmd_t cmd;
  mdrc_sts_t sts;

  mdrc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_req_i.req_type),
    .cfg_we_i      (cfg_we_i),
    .sts_i         (sts),
    .in_stall_o    (in_stall_o),
    .cmd_o         (cmd)
  );

  mdrc_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .element_value_i (in_req_i.element_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_rsp_o       (out_rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/mdrc_checker.sv
// port-level checker for the duplicate row/column removal block, bound to the top level
// depends on mdrc_pkg and the assertion macro header
`default_nettype none
`include "matrix_duplicate_row_col_removal_top_assert.svh"

module mdrc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input mdrc_pkg::mdrc_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mdrc_pkg::mdrc_rsp_t out_rsp_o
);
  import mdrc_pkg::*;

  logic in_seen;
  assign in_seen = in_valid_i && !in_stall_o && (in_req_i.req_type == REQ_READ);

  `MDRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "stalled response changed")
  `MDRC_ASSERT_NOW(a_nodata_zero, clk_i, rst_ni, out_valid_o && out_rsp_o.no_data, (out_rsp_o.result_value == 0) && !out_rsp_o.end_of_row && !out_rsp_o.last_element && (out_rsp_o.kept_rows == 0) && (out_rsp_o.kept_cols == 0), "no-data response carries data")
  `MDRC_ASSERT_NOW(a_last_eor, clk_i, rst_ni, out_valid_o && out_rsp_o.last_element, out_rsp_o.end_of_row && !out_rsp_o.no_data, "last element without end of row")
  `MDRC_ASSERT_NOW(a_kept_dims, clk_i, rst_ni, out_valid_o && !out_rsp_o.no_data, (out_rsp_o.kept_rows != 0) && (out_rsp_o.kept_cols != 0), "zero kept size on data")
  `MDRC_ASSERT_NEXT(a_read_busy, clk_i, rst_ni, in_seen, !(in_valid_i && !in_stall_o && (in_req_i.req_type == REQ_READ) && out_valid_o && out_stall_i), "read accepted onto stalled output")

endmodule

bind matrix_duplicate_row_col_removal_top mdrc_checker u_mdrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

>>> tb/sv/mdrc_rsp_checker.sv
// response checker for the duplicate row/column removal block: follows the
// configuration and request ports, predicts every read response, compares
// depends on mdrc_pkg
module mdrc_rsp_checker #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  mdrc_pkg::mdrc_req_t            in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  mdrc_pkg::mdrc_rsp_t            out_rsp_i,
  input  logic                           cfg_we_i,
  input  logic [mdrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdrc_pkg::DIM_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             outstanding_o,
  output int                             checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mdrc_pkg::*;

  logic signed [DATA_W-1:0] matrix_mem [MAX_ROWS][MAX_COLS];
  int                       loaded_cnt;
  bit [MAX_ROWS-1:0]        row_kept;
  bit [MAX_COLS-1:0]        col_kept;
  bit                       reading;
  int                       rd_row;
  int                       rd_col;
  bit                       rd_done;
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;

  mdrc_rsp_t read_rsp_q [$];
  mdrc_rsp_t new_rsp;
  mdrc_rsp_t want_rsp;
  int        fails;
  int        n_checked;

  assign fail_count_o = fails;
  assign checked_o    = n_checked;

  function automatic int eff_dim(logic [DIM_W-1:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic int next_kept(bit [255:0] mask, int pos, int lim);
    for (int i = pos + 1; i < lim; i++) begin
      if (mask[i]) return i;
    end
    return lim;
  endfunction

  function automatic void restart_matrix();
    loaded_cnt = 0;
    row_kept   = '1;
    col_kept   = '1;
    reading    = 1'b0;
    rd_row     = 0;
    rd_col     = 0;
    rd_done    = 1'b0;
  endfunction

  function automatic void drop_duplicates();
    int nr;
    int nc;
    bit same;
    nr = eff_dim(rows_reg, MAX_ROWS);
    nc = eff_dim(cols_reg, MAX_COLS);
    for (int b = 1; b < nr; b++) begin
      for (int a = 0; a < b && row_kept[b]; a++) begin
        if (row_kept[a]) begin
          same = 1'b1;
          for (int k = 0; k < nc; k++) begin
            if (matrix_mem[a][k] != matrix_mem[b][k]) same = 1'b0;
          end
          if (same) row_kept[b] = 1'b0;
        end
      end
    end
    for (int b = 1; b < nc; b++) begin
      for (int a = 0; a < b && col_kept[b]; a++) begin
        if (col_kept[a]) begin
          same = 1'b1;
          for (int k = 0; k < nr; k++) begin
            if (row_kept[k] && matrix_mem[k][a] != matrix_mem[k][b]) same = 1'b0;
          end
          if (same) col_kept[b] = 1'b0;
        end
      end
    end
    reading = 1'b1;
    rd_row  = 0;
    rd_col  = 0;
    rd_done = 1'b0;
  endfunction

  // returns 1 when the request produces a response
  function automatic bit apply_request(mdrc_req_t req, output mdrc_rsp_t rsp);
    int nr;
    int nc;
    int kr;
    int kc;
    int nxr;
    int nxc;
    bit eor;
    bit lst;
    nr  = eff_dim(rows_reg, MAX_ROWS);
    nc  = eff_dim(cols_reg, MAX_COLS);
    rsp = '0;
    if (req.req_type == REQ_LOAD) begin
      if (reading) restart_matrix();
      if (loaded_cnt < nr * nc) begin
        matrix_mem[loaded_cnt / nc][loaded_cnt % nc] = req.element_value;
        loaded_cnt++;
      end
      if (loaded_cnt >= nr * nc) drop_duplicates();
      return 1'b0;
    end
    if (!reading || rd_done) begin
      rsp.no_data = 1'b1;
      return 1'b1;
    end
    kr = 0;
    kc = 0;
    for (int i = 0; i < nr; i++) if (row_kept[i]) kr++;
    for (int i = 0; i < nc; i++) if (col_kept[i]) kc++;
    nxc = next_kept(col_kept, rd_col, nc);
    nxr = next_kept(row_kept, rd_row, nr);
    eor = (nxc >= nc);
    lst = eor && (nxr >= nr);
    rsp.result_value = matrix_mem[rd_row][rd_col];
    rsp.end_of_row   = eor;
    rsp.last_element = lst;
    rsp.kept_rows    = DIM_W'(kr);
    rsp.kept_cols    = DIM_W'(kc);
    if (lst) begin
      rd_done = 1'b1;
    end else if (eor) begin
      rd_row = nxr;
      rd_col = 0;
    end else begin
      rd_col = nxc;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg = 1;
      cols_reg = 1;
      restart_matrix();
      read_rsp_q.delete();
      fails = 0;
      n_checked = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_ROWS) rows_reg = cfg_data_i;
        else cols_reg = cfg_data_i;
        restart_matrix();
      end
      if (in_valid_i && !in_stall_i) begin
        if (apply_request(in_req_i, new_rsp)) read_rsp_q.push_back(new_rsp);
      end
      if (out_valid_i && !out_stall_i) begin
        if (read_rsp_q.size() == 0) begin
          if (fails < 10) $display("[%0t] response with no read request pending", $realtime);
          fails++;
        end else begin
          want_rsp = read_rsp_q.pop_front();
          n_checked++;
          if (out_rsp_i.result_value !== want_rsp.result_value ||
              out_rsp_i.end_of_row !== want_rsp.end_of_row ||
              out_rsp_i.last_element !== want_rsp.last_element ||
              out_rsp_i.kept_rows !== want_rsp.kept_rows ||
              out_rsp_i.kept_cols !== want_rsp.kept_cols ||
              out_rsp_i.no_data !== want_rsp.no_data) begin
            if (fails < 10) begin
              $display("[%0t] mismatch exp: value=%0d eor=%0b last=%0b rows=%0d cols=%0d nd=%0b",
                       $realtime, want_rsp.result_value, want_rsp.end_of_row,
                       want_rsp.last_element, want_rsp.kept_rows, want_rsp.kept_cols,
                       want_rsp.no_data);
              $display("          got: value=%0d eor=%0b last=%0b rows=%0d cols=%0d nd=%0b",
                       out_rsp_i.result_value, out_rsp_i.end_of_row, out_rsp_i.last_element,
                       out_rsp_i.kept_rows, out_rsp_i.kept_cols, out_rsp_i.no_data);
            end
            fails++;
          end
        end
      end
      outstanding_o <= read_rsp_q.size();
    end
  end

endmodule

>>> tb/sv/matrix_duplicate_row_col_removal_top_tb.sv
// top of the duplicate row/column removal testbench: clock, reset, request and
// configuration stimulus, response stalls and the verdict
// depends on mdrc_pkg, mdrc_rsp_checker and matrix_duplicate_row_col_removal_top
module matrix_duplicate_row_col_removal_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdrc_pkg::*;

  localparam int unsigned MAX_ROWS   = 16;
  localparam int unsigned MAX_COLS   = 16;
  localparam int          CLK_PERIOD = 8;
  localparam int          RAND_ITEMS = 550;
  localparam int          QUIET_TAIL = 70;
  localparam int          HOLD_LEN   = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  mdrc_req_t            in_req_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  mdrc_rsp_t            out_rsp_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIM_W-1:0]     cfg_data_i;

  int fail_count;
  int rsp_outstanding;
  int rsp_checked;

  int                       req_sent;
  int                       cfg_settings;
  int                       rand_target;
  int                       guard;
  bit                       gaps_on;
  bit                       tail_mode;
  bit                       hold_off_req;
  logic [DIM_W-1:0]         rows_raw;
  logic [DIM_W-1:0]         cols_raw;
  logic [DIM_W-1:0]         pick_r;
  logic [DIM_W-1:0]         pick_c;
  logic signed [DATA_W-1:0] tile [MAX_ROWS][MAX_COLS];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  matrix_duplicate_row_col_removal_top #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  mdrc_rsp_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_i    (out_rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .outstanding_o(rsp_outstanding),
    .checked_o    (rsp_checked)
  );

  function automatic int eff_dim(logic [DIM_W-1:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  // bound on the dedupe walk for the current dimensions
  function automatic int walk_cycles();
    int r;
    int c;
    r = eff_dim(rows_raw, MAX_ROWS);
    c = eff_dim(cols_raw, MAX_COLS);
    return r * r * (c + 3) / 2 + c * c * (r + 3) / 2 + 32;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_elem(int pool_sz);
    if (pool_sz == 0) return $urandom;
    case ($urandom_range(0, pool_sz - 1))
      0: return 0;
      1: return -1;
      2: return 32'sh8000_0000;
      3: return 32'sh7fff_ffff;
      default: return 1;
    endcase
  endfunction

  task automatic send_req(logic rt, logic signed [DATA_W-1:0] val);
    mdrc_req_t req;
    req.req_type      = rt;
    req.element_value = val;
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    req_sent++;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rsp_outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_NUM_ROWS) rows_raw = val;
    else cols_raw = val;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
    wait_drained();
    repeat (walk_cycles()) @(posedge clk_i);
    write_reg(CFG_NUM_ROWS, r);
    write_reg(CFG_NUM_COLS, c);
    cfg_settings++;
  endtask

  task automatic read_out(int n);
    repeat (n) send_req(REQ_READ, $urandom);
  endtask

  // builds a matrix rich in repeated rows and columns and loads it
  task automatic load_tile(bit noisy);
    int nr;
    int nc;
    int pool_sz;
    int src;
    nr = eff_dim(rows_raw, MAX_ROWS);
    nc = eff_dim(cols_raw, MAX_COLS);
    case ($urandom_range(0, 3))
      0: pool_sz = 0;
      1: pool_sz = 1;
      2: pool_sz = 2;
      default: pool_sz = 5;
    endcase
    for (int r = 0; r < nr; r++) begin
      if (r > 0 && $urandom_range(0, 2) == 0) begin
        src = $urandom_range(0, r - 1);
        for (int c = 0; c < nc; c++) tile[r][c] = tile[src][c];
      end else begin
        for (int c = 0; c < nc; c++) tile[r][c] = pick_elem(pool_sz);
      end
    end
    for (int c = 1; c < nc; c++) begin
      if ($urandom_range(0, 3) == 0) begin
        src = $urandom_range(0, c - 1);
        for (int r = 0; r < nr; r++) tile[r][c] = tile[r][src];
      end
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (noisy && $urandom_range(0, 15) == 0) send_req(REQ_READ, $urandom);
        send_req(REQ_LOAD, tile[r][c]);
      end
    end
  endtask

  task automatic run_phase(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
    int cells;
    set_dims(r, c);
    cells   = eff_dim(rows_raw, MAX_ROWS) * eff_dim(cols_raw, MAX_COLS);
    gaps_on = !tail_mode && ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 4) != 0) begin
        load_tile($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 5) == 0) wait_drained();
        read_out(cells + $urandom_range(0, 1));
      end else begin
        // partial or just complete matrix; reads get no data unless it is complete
        repeat ($urandom_range(1, cells)) send_req(REQ_LOAD, pick_elem(2));
        read_out($urandom_range(1, 3));
      end
    end
  endtask

  // response side stalls
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 4_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_req_i     <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_NUM_ROWS;
    cfg_data_i   <= '0;
    rows_raw     = 1;
    cols_raw     = 1;
    req_sent     = 0;
    cfg_settings = 0;
    gaps_on      = 1'b0;
    tail_mode    = 1'b0;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 after reset: read while loading, min value, read past the end
    send_req(REQ_READ, 0);
    send_req(REQ_LOAD, 32'sh8000_0000);
    send_req(REQ_READ, 0);
    send_req(REQ_READ, -1);
    // load request after completion starts a new matrix
    send_req(REQ_LOAD, 32'sh7fff_ffff);
    send_req(REQ_READ, 0);
    // all equal 2x2 collapses to one element
    set_dims(2, 2);
    repeat (4) send_req(REQ_LOAD, 5);
    read_out(2);
    // zero rows acts as one, equal outer columns
    set_dims(0, 3);
    send_req(REQ_LOAD, -1);
    send_req(REQ_LOAD, 0);
    send_req(REQ_READ, 0);
    send_req(REQ_LOAD, -1);
    read_out(3);

    rand_target = req_sent + RAND_ITEMS;
    run_phase(31, 2);
    run_phase(1, 16);
    run_phase(17, 0);

    // long response hold-off while read requests keep coming
    set_dims(3, 3);
    gaps_on = 1'b1;
    load_tile(1'b0);
    hold_off_req = 1'b1;
    read_out(10);
    wait_drained();
    read_out(2);

    while (req_sent < rand_target - QUIET_TAIL) begin
      if ($urandom_range(0, 7) == 0) begin
        pick_r = DIM_W'($urandom_range(0, 31));
        pick_c = DIM_W'($urandom_range(1, 3));
        if ($urandom_range(0, 1) == 0) run_phase(pick_r, pick_c);
        else run_phase(pick_c, pick_r);
      end else begin
        run_phase(DIM_W'($urandom_range(1, 6)), DIM_W'($urandom_range(1, 6)));
      end
    end

    // quiet tail, no idling on either side
    tail_mode = 1'b1;
    gaps_on   = 1'b0;
    while (req_sent < rand_target) begin
      run_phase(DIM_W'($urandom_range(1, 3)), DIM_W'($urandom_range(1, 3)));
    end

    in_valid_i <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (rsp_outstanding != 0 && guard < 100000);
    repeat (walk_cycles()) @(posedge clk_i);

    $display("%0d requests sent across %0d register settings, %0d responses compared",
             req_sent, cfg_settings, rsp_checked);
    if (fail_count == 0 && rsp_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      if (rsp_outstanding != 0) $display("%0d responses never arrived", rsp_outstanding);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> matrix_duplicate_row_col_removal_top.f
+incdir+rtl
rtl/mdrc_pkg.sv
rtl/mdrc_ram.sv
rtl/mdrc_ctrl.sv
rtl/mdrc_dp.sv
rtl/matrix_duplicate_row_col_removal_top.sv
rtl/mdrc_checker.sv
tb/sv/mdrc_rsp_checker.sv
tb/sv/matrix_duplicate_row_col_removal_top_tb.sv
